@@ design/dtes_pkg.sv @@
// ----------------------------------------------------------------------------
// dtes_pkg: shared types and constants of the dual tone envelope synthesizer
// Sequencer states, divider request/response bundles and fixed coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package dtes_pkg;

  // Frame count clamp
  localparam int MAX_FRAMES = 16384;

  // Noise generator
  localparam logic [31:0] NOISE_SEED = 32'hACE1_ACE1;
  localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;
  localparam logic [16:0] NOISE_GAIN = 17'd32767;

  // Fade register
  localparam logic [11:0] FADE_RESET      = 12'd80;
  localparam logic        REG_FADE_LENGTH = 1'b0;

  // Quarter-wave polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42178;
  localparam logic [16:0] SIN_C = 17'd4769;

  localparam logic [15:0] SAMPLE_MAX = 16'd32767;

  // Shared datapath widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 51;
  localparam int DIV_W   = 32;
  localparam int DEN_W   = 12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOISE_SHIFT,
    ST_NOISE_MUL1,
    ST_NOISE_MUL2,
    ST_SIN_XX,
    ST_SIN_XC,
    ST_SIN_XI,
    ST_SIN_XM,
    ST_SIN_ACC,
    ST_TONE_MUL1,
    ST_TONE_MUL2,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } dtes_state_t;

  typedef enum logic {
    OSC_A,
    OSC_B
  } osc_sel_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/dtes_chan_if.sv @@
// ----------------------------------------------------------------------------
// dtes_chan_if: request and result channels of the synthesizer
// Valid/ready channels carrying one frame request and one sample result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtes_in_if;
  logic        valid;
  logic        ready;
  logic        restart_phase;
  logic        noise_mode;
  logic [31:0] increment_a;
  logic [31:0] increment_b;
  logic [15:0] amplitude;
  logic [13:0] frame_index;
  logic [14:0] segment_length;

  modport source (
    output valid, restart_phase, noise_mode, increment_a, increment_b,
           amplitude, frame_index, segment_length,
    input  ready
  );

  modport sink (
    input  valid, restart_phase, noise_mode, increment_a, increment_b,
           amplitude, frame_index, segment_length,
    output ready
  );
endinterface

interface dtes_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

@@ design/dtes_div.sv @@
// ----------------------------------------------------------------------------
// dtes_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtes_div
  import dtes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] count_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        count_r <= '0;
      end else if (busy_r) begin
        count_r <= count_r + 1'b1;
        if (count_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

@@ design/dual_tone_envelope_synth.sv @@
// ----------------------------------------------------------------------------
// dual_tone_envelope_synth: two-oscillator tone and noise frame synthesizer
// Each request renders one audio frame. In tone mode the sines of two phase
// accumulators are summed (halved when both run), the phases advance, and the
// sum is scaled by the amplitude and a linear fade-in/fade-out envelope; both
// increments zero give silence. In noise mode 16 steps of a 32-bit Galois
// LFSR give a value in [-1,1) scaled by the amplitude. Samples truncate toward
// zero and saturate to +-32767. All arithmetic runs through one shared
// 34x17 multiplier and one restoring divider under a small sequencer, so the
// block takes one request at a time, and the sample reaches the output
// register as the block becomes ready again. On tone frames the divider
// takes most of the time: a start, the quotient bits one after another and a
// done strobe. Each oscillator runs the sine polynomial on the multiplier and
// then accumulates; gain and envelope take a multiply each. Noise frames run
// their LFSR shifts, then multiply by the amplitude and the noise gain, and
// scale by a shift instead of a division. A finished sample waits in the
// output register while the next request is already being worked on; if
// that sample is still waiting when the next one is ready, the block holds
// until it leaves. The fade length register sits at byte address 0 of the
// APB port, resets to 80 and takes effect on the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_tone_envelope_synth
  import dtes_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dtes_in_if.sink     in_chan,
  dtes_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Quarter-wave index bits and the shift that brings x to Q16
  localparam int QB  = SINE_TABLE_BITS - 2;
  localparam int XSH = 16 - QB;
  localparam logic [QB:0] QN = {1'b1, {QB{1'b0}}};

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  dtes_state_t            state_r, state_nxt;
  logic [11:0]            fade_r;
  logic [PHASE_BITS-1:0]  phase_a_r, phase_b_r;
  logic [31:0]            lfsr_r;
  logic                   out_valid_r;
  logic [15:0]            out_sample_r;

  logic                   noise_r, dual_r, in_seg_r;
  logic [PHASE_BITS-1:0]  inc_a_r, inc_b_r;
  logic [15:0]            amp_r;
  logic [11:0]            num_r, den_r;
  osc_sel_t               osc_r;
  logic [16:0]            x_r, x2_r;
  logic signed [16:0]     sum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [3:0]             shift_cnt_r;
  logic                   neg_r;
  logic [DIV_W-1:0]       quo_r;

  // --------------------------------------------------------------------------
  // Handshakes and configuration
  // --------------------------------------------------------------------------
  logic in_accept, out_load, cfg_write;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FADE_LENGTH);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FADE_LENGTH) ? {20'b0, fade_r} : '0;

  // --------------------------------------------------------------------------
  // Request decode: clamp the segment and work out the envelope fraction
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] inc_a_in, inc_b_in;
  logic [14:0]           count_c;
  logic [12:0]           twice_fade;
  logic [11:0]           fade_c;
  logic [11:0]           num_c, den_c;
  logic                  in_seg_c;

  assign inc_a_in = in_chan.increment_a[PHASE_BITS-1:0];
  assign inc_b_in = in_chan.increment_b[PHASE_BITS-1:0];

  always_comb begin
    count_c = ({2'b0, in_chan.segment_length} > 17'(MAX_FRAMES)) ?
              15'(MAX_FRAMES) : in_chan.segment_length;
    in_seg_c   = {1'b0, in_chan.frame_index} < count_c;
    twice_fade = {fade_r, 1'b0};
    // Short segments fade over a quarter of their length
    fade_c = (count_c < {2'b0, twice_fade}) ? count_c[13:2] : fade_r;
    num_c  = 12'd1;
    den_c  = 12'd1;
    if (fade_c != '0) begin
      if (in_chan.frame_index < {2'b0, fade_c}) begin
        num_c = in_chan.frame_index[11:0];
        den_c = fade_c;
      end else if ({1'b0, in_chan.frame_index} >= count_c - {3'b0, fade_c}) begin
        num_c = 12'(count_c - {1'b0, in_chan.frame_index});
        den_c = fade_c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sine operand of the selected oscillator
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0]      phase_sel;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [1:0]                 quad;
  logic [QB-1:0]              rq;
  logic [QB:0]                xq;
  logic [16:0]                x_c;
  logic [16:0]                y_half;
  logic [15:0]                v_c;
  logic signed [16:0]         sum_add;

  always_comb begin
    phase_sel = (osc_r == OSC_A) ? phase_a_r : phase_b_r;
    sidx      = phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad      = sidx[SINE_TABLE_BITS-1 -: 2];
    rq        = sidx[QB-1:0];
    // Mirror the odd quarters
    xq        = quad[0] ? (QN - {1'b0, rq}) : {1'b0, rq};
    x_c       = 17'(xq) << XSH;
    // Q15 sine is y/2, clamped to full scale
    y_half    = prod_r[33:17];
    v_c       = (y_half > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : y_half[15:0];
    sum_add   = quad[1] ? (sum_r - $signed({1'b0, v_c})) : (sum_r + $signed({1'b0, v_c}));
  end

  // --------------------------------------------------------------------------
  // LFSR step, noise value, divider operands and saturation
  // --------------------------------------------------------------------------
  logic [31:0]        lfsr_step;
  logic signed [15:0] noise_n;
  logic [PROD_W-1:0]  mag_u;
  logic [DIV_W-1:0]   dividend_c;
  logic [15:0]        sat_c;
  logic [15:0]        sample_c;

  always_comb begin
    lfsr_step  = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? NOISE_TAPS : 32'b0);
    // r - 32768 is r with its top bit flipped, read as signed
    noise_n    = $signed({~lfsr_r[15], lfsr_r[14:0]});
    mag_u      = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    if (noise_r) begin
      dividend_c = DIV_W'(mag_u >> 31);
    end else if (dual_r) begin
      dividend_c = DIV_W'(mag_u >> 17);
    end else begin
      dividend_c = DIV_W'(mag_u >> 16);
    end
    sat_c    = (quo_r > DIV_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quo_r[15:0];
    sample_c = neg_r ? (16'd0 - sat_c) : sat_c;
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and divider
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  dtes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (in_chan.noise_mode) begin
            state_nxt = ST_NOISE_SHIFT;
          end else if (inc_a_in == '0 && inc_b_in == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SIN_XX;
          end
        end
      end
      ST_NOISE_SHIFT: begin
        if (shift_cnt_r == 4'hF) begin
          state_nxt = ST_NOISE_MUL1;
        end
      end
      ST_NOISE_MUL1: state_nxt = ST_NOISE_MUL2;
      ST_NOISE_MUL2: state_nxt = ST_DIV_START;
      ST_SIN_XX:     state_nxt = ST_SIN_XC;
      ST_SIN_XC:     state_nxt = ST_SIN_XI;
      ST_SIN_XI:     state_nxt = ST_SIN_XM;
      ST_SIN_XM:     state_nxt = ST_SIN_ACC;
      ST_SIN_ACC: begin
        priority if (osc_r == OSC_A && inc_b_r != '0) begin
          state_nxt = ST_SIN_XX;
        end else if (in_seg_r) begin
          state_nxt = ST_TONE_MUL1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_TONE_MUL1:  state_nxt = ST_TONE_MUL2;
      ST_TONE_MUL2:  state_nxt = ST_DIV_START;
      // Noise scales by a shift alone and skips the divider
      ST_DIV_START:  state_nxt = noise_r ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (ready, multiplier operands, divider request)
  // --------------------------------------------------------------------------
  always_comb begin
    in_chan.ready    = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    mul_en           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = dividend_c;
    div_req.divisor  = den_r;
    unique case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_SIN_XX: begin
        mul_a  = {17'b0, x_c};
        mul_b  = x_c;
        mul_en = 1'b1;
      end
      ST_SIN_XC: begin
        mul_a  = {17'b0, prod_r[32:16]};
        mul_b  = SIN_C;
        mul_en = 1'b1;
      end
      ST_SIN_XI: begin
        mul_a  = {17'b0, x2_r};
        mul_b  = SIN_B - prod_r[32:16];
        mul_en = 1'b1;
      end
      ST_SIN_XM: begin
        mul_a  = {17'b0, x_r};
        mul_b  = SIN_A - prod_r[32:16];
        mul_en = 1'b1;
      end
      ST_TONE_MUL1: begin
        mul_a  = {{17{sum_r[16]}}, sum_r};
        mul_b  = {1'b0, amp_r};
        mul_en = 1'b1;
      end
      ST_TONE_MUL2: begin
        mul_a  = prod_r[MUL_A_W-1:0];
        mul_b  = {5'b0, num_r};
        mul_en = 1'b1;
      end
      ST_NOISE_MUL1: begin
        mul_a  = {{18{noise_n[15]}}, noise_n};
        mul_b  = {1'b0, amp_r};
        mul_en = 1'b1;
      end
      ST_NOISE_MUL2: begin
        mul_a  = prod_r[MUL_A_W-1:0];
        mul_b  = NOISE_GAIN;
        mul_en = 1'b1;
      end
      ST_DIV_START: div_req.start = !noise_r;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fade_r      <= FADE_RESET;
      phase_a_r   <= '0;
      phase_b_r   <= '0;
      lfsr_r      <= NOISE_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        fade_r <= pwdata[11:0];
      end
      // Restart clears both phases in every mode
      if (in_accept && in_chan.restart_phase) begin
        phase_a_r <= '0;
        phase_b_r <= '0;
      end
      // Advance the oscillator whose sine was just taken
      if (state_r == ST_SIN_ACC) begin
        if (osc_r == OSC_A) begin
          phase_a_r <= phase_a_r + inc_a_r;
        end else begin
          phase_b_r <= phase_b_r + inc_b_r;
        end
      end
      if (state_r == ST_NOISE_SHIFT) begin
        lfsr_r <= lfsr_step;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      noise_r     <= in_chan.noise_mode;
      inc_a_r     <= inc_a_in;
      inc_b_r     <= inc_b_in;
      amp_r       <= in_chan.amplitude;
      num_r       <= num_c;
      den_r       <= den_c;
      in_seg_r    <= in_seg_c;
      dual_r      <= (inc_a_in != '0) && (inc_b_in != '0);
      osc_r       <= (inc_a_in != '0) ? OSC_A : OSC_B;
      shift_cnt_r <= '0;
      sum_r       <= '0;
      // Silent frames leave with a zero quotient
      neg_r       <= 1'b0;
      quo_r       <= '0;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    unique case (state_r)
      ST_NOISE_SHIFT: shift_cnt_r <= shift_cnt_r + 1'b1;
      ST_SIN_XX:      x_r  <= x_c;
      ST_SIN_XC:      x2_r <= prod_r[32:16];
      ST_SIN_ACC: begin
        sum_r <= sum_add;
        if (osc_r == OSC_A && inc_b_r != '0) begin
          osc_r <= OSC_B;
        end
      end
      ST_DIV_START: begin
        neg_r <= prod_r[PROD_W-1];
        // Take the shifted noise magnitude as the quotient directly
        if (noise_r) begin
          quo_r <= dividend_c;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          quo_r <= div_rsp.quotient;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_sample_r <= sample_c;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = $signed(out_sample_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_done_in_wait: assert property (
    @(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT)
  ) else $error("divider finished outside of its wait state");

  a_div_divisor_nonzero: assert property (
    @(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0)
  ) else $error("division started with a zero divisor");

  a_noise_holds_phase: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_NOISE_SHIFT && $past(state_r) == ST_NOISE_SHIFT) |->
      ($stable(phase_a_r) && $stable(phase_b_r))
  ) else $error("phase moved during a noise frame");

  a_emit_waits_for_slot: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_chan.ready) |=>
      (state_r == ST_EMIT && out_valid_r)
  ) else $error("sample overwrote a result still waiting");

endmodule

`default_nettype wire
